// ===== src/rti_pkg.sv =====
// shared types, codes and the multiply sequence for the ray/triangle intersect block
package rti_pkg;

    localparam int PC_W = 6;

    typedef enum logic [2:0] {
        SLOT_ORIGIN = 3'd0,
        SLOT_DIR    = 3'd1,
        SLOT_VA     = 3'd2,
        SLOT_VB     = 3'd3,
        SLOT_VC     = 3'd4
    } t_slot;

    typedef enum logic [3:0] {
        MV_DA, MV_DB, MV_DN, MV_X1, MV_X2, MV_X3, MV_DET, MV_N0, MV_N1
    } t_mvec;

    typedef enum logic [2:0] {
        QV_DA, QV_DB, QV_DR, QV_DN, QV_VA
    } t_qvec;

    typedef enum logic [2:0] {
        DS_NONE, DS_X1, DS_X2, DS_X3, DS_DET, DS_N0, DS_N1, DS_N2
    } t_dst;

    typedef enum logic [1:0] {
        NX_MUL, NX_CHECK, NX_DIV
    } t_next;

    typedef enum logic [1:0] {
        RI_DIST = 2'd0,
        RI_X    = 2'd1,
        RI_Y    = 2'd2,
        RI_Z    = 2'd3
    } t_ridx;

    typedef enum logic [3:0] {
        S_IDLE, S_MSTART, S_MRUN, S_ZCHK, S_HCHK, S_DSTART, S_DRUN, S_MISS, S_PUB
    } t_state;

    typedef struct packed {
        t_mvec      mv;
        logic [1:0] mc;
        t_qvec      qv;
        logic [1:0] qc;
        logic       clr;
        logic       sub;
        t_dst       dst;
        logic [1:0] dc;
        t_next      nx;
    } t_uop;

    typedef struct packed {
        logic  in_fire;
        logic  mul_start;
        logic  store;
        logic  norm;
        logic  div_start;
        logic  div_dist;
        logic  res_store;
        t_ridx res_idx;
        logic  res_miss;
        logic  publish;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic det_zero;
        logic hit_ok;
    } t_stat;

    function automatic t_uop mk(input t_mvec mv, input logic [1:0] mc, input t_qvec qv,
                                input logic [1:0] qc, input logic clr, input logic sub,
                                input t_dst dst, input logic [1:0] dc, input t_next nx);
        t_uop u;
        u.mv  = mv;
        u.mc  = mc;
        u.qv  = qv;
        u.qc  = qc;
        u.clr = clr;
        u.sub = sub;
        u.dst = dst;
        u.dc  = dc;
        u.nx  = nx;
        return u;
    endfunction

    // x1 = db x dn, x2 = da x dn, x3 = da x db, then det/n0/n1/n2 as dot products,
    // then the three point numerators
    function automatic t_uop rti_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(MV_DA, 2'd0, QV_DA, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
        case (pc)
            6'd0:  u = mk(MV_DB, 2'd1, QV_DN, 2'd2, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd1:  u = mk(MV_DB, 2'd2, QV_DN, 2'd1, 1'b0, 1'b1, DS_X1,   2'd0, NX_MUL);
            6'd2:  u = mk(MV_DB, 2'd2, QV_DN, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd3:  u = mk(MV_DB, 2'd0, QV_DN, 2'd2, 1'b0, 1'b1, DS_X1,   2'd1, NX_MUL);
            6'd4:  u = mk(MV_DB, 2'd0, QV_DN, 2'd1, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd5:  u = mk(MV_DB, 2'd1, QV_DN, 2'd0, 1'b0, 1'b1, DS_X1,   2'd2, NX_MUL);
            6'd6:  u = mk(MV_DA, 2'd1, QV_DN, 2'd2, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd7:  u = mk(MV_DA, 2'd2, QV_DN, 2'd1, 1'b0, 1'b1, DS_X2,   2'd0, NX_MUL);
            6'd8:  u = mk(MV_DA, 2'd2, QV_DN, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd9:  u = mk(MV_DA, 2'd0, QV_DN, 2'd2, 1'b0, 1'b1, DS_X2,   2'd1, NX_MUL);
            6'd10: u = mk(MV_DA, 2'd0, QV_DN, 2'd1, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd11: u = mk(MV_DA, 2'd1, QV_DN, 2'd0, 1'b0, 1'b1, DS_X2,   2'd2, NX_MUL);
            6'd12: u = mk(MV_DA, 2'd1, QV_DB, 2'd2, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd13: u = mk(MV_DA, 2'd2, QV_DB, 2'd1, 1'b0, 1'b1, DS_X3,   2'd0, NX_MUL);
            6'd14: u = mk(MV_DA, 2'd2, QV_DB, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd15: u = mk(MV_DA, 2'd0, QV_DB, 2'd2, 1'b0, 1'b1, DS_X3,   2'd1, NX_MUL);
            6'd16: u = mk(MV_DA, 2'd0, QV_DB, 2'd1, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd17: u = mk(MV_DA, 2'd1, QV_DB, 2'd0, 1'b0, 1'b1, DS_X3,   2'd2, NX_MUL);
            6'd18: u = mk(MV_X1, 2'd0, QV_DA, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd19: u = mk(MV_X1, 2'd1, QV_DA, 2'd1, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd20: u = mk(MV_X1, 2'd2, QV_DA, 2'd2, 1'b0, 1'b0, DS_DET,  2'd0, NX_MUL);
            6'd21: u = mk(MV_X1, 2'd0, QV_DR, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd22: u = mk(MV_X1, 2'd1, QV_DR, 2'd1, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd23: u = mk(MV_X1, 2'd2, QV_DR, 2'd2, 1'b0, 1'b0, DS_N0,   2'd0, NX_MUL);
            6'd24: u = mk(MV_X2, 2'd0, QV_DR, 2'd0, 1'b1, 1'b1, DS_NONE, 2'd0, NX_MUL);
            6'd25: u = mk(MV_X2, 2'd1, QV_DR, 2'd1, 1'b0, 1'b1, DS_NONE, 2'd0, NX_MUL);
            6'd26: u = mk(MV_X2, 2'd2, QV_DR, 2'd2, 1'b0, 1'b1, DS_N1,   2'd0, NX_MUL);
            6'd27: u = mk(MV_X3, 2'd0, QV_DR, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd28: u = mk(MV_X3, 2'd1, QV_DR, 2'd1, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd29: u = mk(MV_X3, 2'd2, QV_DR, 2'd2, 1'b0, 1'b0, DS_N2,   2'd0, NX_CHECK);
            6'd30: u = mk(MV_DET, 2'd0, QV_VA, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd31: u = mk(MV_N0,  2'd0, QV_DA, 2'd0, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd32: u = mk(MV_N1,  2'd0, QV_DB, 2'd0, 1'b0, 1'b0, DS_NONE, 2'd0, NX_DIV);
            6'd33: u = mk(MV_DET, 2'd0, QV_VA, 2'd1, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd34: u = mk(MV_N0,  2'd0, QV_DA, 2'd1, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd35: u = mk(MV_N1,  2'd0, QV_DB, 2'd1, 1'b0, 1'b0, DS_NONE, 2'd0, NX_DIV);
            6'd36: u = mk(MV_DET, 2'd0, QV_VA, 2'd2, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd37: u = mk(MV_N0,  2'd0, QV_DA, 2'd2, 1'b0, 1'b0, DS_NONE, 2'd0, NX_MUL);
            6'd38: u = mk(MV_N1,  2'd0, QV_DB, 2'd2, 1'b0, 1'b0, DS_NONE, 2'd0, NX_DIV);
            default: u = mk(MV_DA, 2'd0, QV_DA, 2'd0, 1'b1, 1'b0, DS_NONE, 2'd0, NX_MUL);
        endcase
        return u;
    endfunction

endpackage

// ===== src/rti_div.sv =====
// restoring divider with round-half-away numerator prepared outside, saturating result
module rti_div #(
    parameter int COORD_WIDTH = 32,
    parameter int ACC_WIDTH   = 137
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ACC_WIDTH-1:0]   i_dvd,
    input  logic [ACC_WIDTH-1:0]   i_den,
    input  logic                   i_neg,
    output logic                   o_busy,
    output logic [COORD_WIDTH-1:0] o_res
);
    localparam int AW  = ACC_WIDTH;
    localparam int W   = COORD_WIDTH;
    localparam int CNW = $clog2(AW);

    logic [AW-1:0]  r_dvd;
    logic [AW:0]    r_den2;
    logic [AW:0]    r_rem;
    logic [AW-1:0]  r_q;
    logic           r_neg;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;

    logic [AW:0]    w_rsh;
    logic           w_ge;
    logic [AW-1:0]  w_lim;
    logic [AW-1:0]  w_qs;
    logic [AW-1:0]  w_negq;

    assign w_rsh = {r_rem[AW-1:0], r_dvd[AW-1]};
    assign w_ge  = w_rsh >= r_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNW'(AW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dvd;
            r_den2 <= {i_den, 1'b0};
            r_rem  <= '0;
            r_q    <= '0;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rsh - r_den2) : w_rsh;
            r_q   <= {r_q[AW-2:0], w_ge};
            r_dvd <= {r_dvd[AW-2:0], 1'b0};
        end
    end

    // negative side may reach one code further
    assign w_lim  = r_neg ? (AW'(1) << (W - 1)) : ((AW'(1) << (W - 1)) - AW'(1));
    assign w_qs   = (r_q > w_lim) ? w_lim : r_q;
    assign w_negq = '0 - w_qs;
    assign o_res  = r_neg ? w_negq[W-1:0] : w_qs[W-1:0];
    assign o_busy = r_busy;

endmodule

// ===== src/rti_dp.sv =====
// datapath: vector store, serial multiply-accumulate, hit test and result registers
module rti_dp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rti_pkg::t_cmd          i_cmd,
    input  rti_pkg::t_uop          i_uop,
    input  logic [2:0]             i_slot,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic [COORD_WIDTH-1:0] i_z,
    output rti_pkg::t_stat         o_stat,
    output logic                   o_hit,
    output logic [COORD_WIDTH-1:0] o_dist,
    output logic [COORD_WIDTH-1:0] o_px,
    output logic [COORD_WIDTH-1:0] o_py,
    output logic [COORD_WIDTH-1:0] o_pz
);
    import rti_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int D   = W + 1;
    localparam int AW  = 4 * W + 9;
    localparam int MCW = $clog2(D);

    logic signed [W-1:0]  w_in [3];
    logic signed [W-1:0]  r_vo [3];
    logic signed [W-1:0]  r_vd [3];
    logic signed [W-1:0]  r_va [3];
    logic signed [W-1:0]  r_vb [3];
    logic signed [D-1:0]  r_da [3];
    logic signed [D-1:0]  r_db [3];
    logic signed [D-1:0]  r_dr [3];
    logic signed [D-1:0]  r_dn [3];
    logic signed [AW-1:0] r_x1 [3];
    logic signed [AW-1:0] r_x2 [3];
    logic signed [AW-1:0] r_x3 [3];
    logic signed [AW-1:0] r_det;
    logic signed [AW-1:0] r_n0;
    logic signed [AW-1:0] r_n1;
    logic signed [AW-1:0] r_n2;

    logic signed [AW-1:0] r_m;
    logic signed [D-1:0]  r_q;
    logic signed [AW-1:0] r_acc;
    logic                 r_sub;
    logic [MCW-1:0]       r_cnt;
    logic                 r_busy;

    logic                 r_res_hit;
    logic [W-1:0]         r_res_dist;
    logic [W-1:0]         r_res_px;
    logic [W-1:0]         r_res_py;
    logic [W-1:0]         r_res_pz;
    logic                 r_out_hit;
    logic [W-1:0]         r_out_dist;
    logic [W-1:0]         r_out_px;
    logic [W-1:0]         r_out_py;
    logic [W-1:0]         r_out_pz;

    logic signed [AW-1:0] w_msel;
    logic signed [D-1:0]  w_qsel;
    logic signed [AW-1:0] w_add;
    logic signed [AW-1:0] w_acc_nx;
    logic                 w_last;
    logic signed [AW-1:0] w_sum;
    logic signed [AW-1:0] w_num;
    logic [AW-1:0]        w_mag;
    logic [AW-1:0]        w_dvd;
    logic                 w_div_busy;
    logic [W-1:0]         w_div_res;

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;

    // vector store and edge vectors, latched when vertex c arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vo[i] <= '0;
                r_vd[i] <= '0;
                r_va[i] <= '0;
                r_vb[i] <= '0;
            end
        end else if (i_cmd.in_fire) begin
            case (i_slot)
                SLOT_ORIGIN: for (int i = 0; i < 3; i++) r_vo[i] <= w_in[i];
                SLOT_DIR:    for (int i = 0; i < 3; i++) r_vd[i] <= w_in[i];
                SLOT_VA:     for (int i = 0; i < 3; i++) r_va[i] <= w_in[i];
                SLOT_VB:     for (int i = 0; i < 3; i++) r_vb[i] <= w_in[i];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_fire && i_slot == SLOT_VC) begin
            for (int i = 0; i < 3; i++) begin
                r_da[i] <= D'(r_vb[i]) - D'(r_va[i]);
                r_db[i] <= D'(w_in[i]) - D'(r_va[i]);
                r_dr[i] <= D'(r_vo[i]) - D'(r_va[i]);
                r_dn[i] <= '0 - D'(r_vd[i]);
            end
        end
    end

    always_comb begin
        case (i_uop.mv)
            MV_DA:   w_msel = AW'(r_da[i_uop.mc]);
            MV_DB:   w_msel = AW'(r_db[i_uop.mc]);
            MV_DN:   w_msel = AW'(r_dn[i_uop.mc]);
            MV_X1:   w_msel = r_x1[i_uop.mc];
            MV_X2:   w_msel = r_x2[i_uop.mc];
            MV_X3:   w_msel = r_x3[i_uop.mc];
            MV_DET:  w_msel = r_det;
            MV_N0:   w_msel = r_n0;
            MV_N1:   w_msel = r_n1;
            default: w_msel = '0;
        endcase
    end

    always_comb begin
        case (i_uop.qv)
            QV_DA:   w_qsel = r_da[i_uop.qc];
            QV_DB:   w_qsel = r_db[i_uop.qc];
            QV_DR:   w_qsel = r_dr[i_uop.qc];
            QV_DN:   w_qsel = r_dn[i_uop.qc];
            QV_VA:   w_qsel = D'(r_va[i_uop.qc]);
            default: w_qsel = '0;
        endcase
    end

    // radix-2 signed multiply: the top bit of the multiplier weighs negative
    assign w_last   = r_cnt == MCW'(D - 1);
    assign w_add    = r_q[0] ? r_m : '0;
    assign w_acc_nx = (w_last ^ r_sub) ? (r_acc - w_add) : (r_acc + w_add);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.mul_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_m   <= w_msel;
            r_q   <= w_qsel;
            r_sub <= i_uop.sub;
            if (i_uop.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= w_acc_nx;
            r_m   <= r_m <<< 1;
            r_q   <= r_q >>> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_uop.dst)
                DS_X1:  r_x1[i_uop.dc] <= r_acc;
                DS_X2:  r_x2[i_uop.dc] <= r_acc;
                DS_X3:  r_x3[i_uop.dc] <= r_acc;
                DS_DET: r_det <= r_acc;
                DS_N0:  r_n0  <= r_acc;
                DS_N1:  r_n1  <= r_acc;
                DS_N2:  r_n2  <= r_acc;
                default: ;
            endcase
        end else if (i_cmd.norm && r_det[AW-1]) begin
            // make the determinant positive, numerators follow
            r_det <= '0 - r_det;
            r_n0  <= '0 - r_n0;
            r_n1  <= '0 - r_n1;
            r_n2  <= '0 - r_n2;
        end
    end

    assign w_sum = r_n0 + r_n1;

    assign o_stat.mul_busy = r_busy;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.det_zero = r_det == '0;
    assign o_stat.hit_ok   = !r_n0[AW-1] && !r_n1[AW-1] && (w_sum <= r_det);

    // rounded quotient = floor((2|num| + det) / (2 det))
    assign w_num = i_cmd.div_dist ? (r_n2 <<< FRAC_BITS) : r_acc;
    assign w_mag = w_num[AW-1] ? ('0 - w_num) : w_num;
    assign w_dvd = {w_mag[AW-2:0], 1'b0} + r_det;

    rti_div #(
        .COORD_WIDTH (W),
        .ACC_WIDTH   (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (w_dvd),
        .i_den   (r_det),
        .i_neg   (w_num[AW-1]),
        .o_busy  (w_div_busy),
        .o_res   (w_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_miss) begin
            r_res_hit  <= 1'b0;
            r_res_dist <= '0;
            r_res_px   <= '0;
            r_res_py   <= '0;
            r_res_pz   <= '0;
        end else if (i_cmd.res_store) begin
            r_res_hit <= 1'b1;
            case (i_cmd.res_idx)
                RI_DIST: r_res_dist <= w_div_res;
                RI_X:    r_res_px   <= w_div_res;
                RI_Y:    r_res_py   <= w_div_res;
                RI_Z:    r_res_pz   <= w_div_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_hit  <= r_res_hit;
            r_out_dist <= r_res_dist;
            r_out_px   <= r_res_px;
            r_out_py   <= r_res_py;
            r_out_pz   <= r_res_pz;
        end
    end

    assign o_hit  = r_out_hit;
    assign o_dist = r_out_dist;
    assign o_px   = r_out_px;
    assign o_py   = r_out_py;
    assign o_pz   = r_out_pz;

endmodule

// ===== src/rti_ctrl.sv =====
// controller: sequences multiplies, hit checks and divides, owns the handshakes
module rti_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [2:0]     i_slot,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rti_pkg::t_stat i_stat,
    output rti_pkg::t_cmd  o_cmd,
    output rti_pkg::t_uop  o_uop
);
    import rti_pkg::*;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ridx           r_oidx, n_oidx;
    logic            r_out_valid, n_out_valid;
    t_uop            w_uop;

    assign w_uop = rti_uop(r_pc);
    assign o_uop = w_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_oidx      <= RI_DIST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_oidx      <= n_oidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_oidx     = r_oidx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_fire = 1'b1;
                    if (i_slot == SLOT_VC) begin
                        n_pc    = '0;
                        n_state = S_MSTART;
                    end
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MRUN;
            end
            S_MRUN: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.store = 1'b1;
                    n_pc        = r_pc + 1'b1;
                    case (w_uop.nx)
                        NX_CHECK: n_state = S_ZCHK;
                        NX_DIV:   n_state = S_DSTART;
                        default:  n_state = S_MSTART;
                    endcase
                end
            end
            S_ZCHK: begin
                if (i_stat.det_zero) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.norm = 1'b1;
                    n_state    = S_HCHK;
                end
            end
            S_HCHK: begin
                if (i_stat.hit_ok) begin
                    n_oidx  = RI_DIST;
                    n_state = S_DSTART;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_dist  = r_oidx == RI_DIST;
                n_state         = S_DRUN;
            end
            S_DRUN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.res_store = 1'b1;
                    o_cmd.res_idx   = r_oidx;
                    if (r_oidx == RI_Z) begin
                        n_state = S_PUB;
                    end else begin
                        n_oidx  = t_ridx'(r_oidx + 2'd1);
                        n_state = S_MSTART;
                    end
                end
            end
            S_MISS: begin
                o_cmd.res_miss = 1'b1;
                n_state        = S_PUB;
            end
            S_PUB: begin
                // wait until the previous result beat has left
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/ray_triangle_intersect_top.sv =====
// origin, direction and vertex a/b beats are stored while idle; a vertex c beat starts the
// multiply, hit check and divide sequence, longer on a hit than on a miss; its length is
// set by the single bit-serial multiplier and divider
// one item in flight; a finished result waits in the output register while new beats enter
// synchronous active-low reset clears the stored vectors and all control state
// top level of the ray/triangle intersect block
module ray_triangle_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // x_value, y_value, z_value
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         i_s_axis_tdata,
    // slot
    input  logic [2:0]                                 i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // hit_distance, hit_x, hit_y, hit_z
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]         o_m_axis_tdata,
    // hit
    output logic [0:0]                                 o_m_axis_tuser
);
    import rti_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int OUT_DW = ((4 * W + 7) / 8) * 8;

    t_cmd         w_cmd;
    t_uop         w_uop;
    t_stat        w_stat;
    logic         w_hit;
    logic [W-1:0] w_dist;
    logic [W-1:0] w_px;
    logic [W-1:0] w_py;
    logic [W-1:0] w_pz;

    rti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_slot      (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_uop       (w_uop)
    );

    rti_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_uop   (w_uop),
        .i_slot  (i_s_axis_tuser),
        .i_x     (i_s_axis_tdata[W-1:0]),
        .i_y     (i_s_axis_tdata[2*W-1:W]),
        .i_z     (i_s_axis_tdata[3*W-1:2*W]),
        .o_stat  (w_stat),
        .o_hit   (w_hit),
        .o_dist  (w_dist),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_pz    (w_pz)
    );

    assign o_m_axis_tdata = OUT_DW'({w_pz, w_py, w_px, w_dist});
    assign o_m_axis_tuser = w_hit;

`ifndef SYNTHESIS
    // no new beat is taken while a multiply or divide is running
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!w_stat.mul_busy && !w_stat.div_busy))
        else $error("input ready while arithmetic busy");

    // a miss carries all-zero data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("miss with nonzero data");

    // a result is only published into a free output register
    a_pub_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwritten before taken");
`endif

endmodule

// ===== bench/ray_triangle_intersect_top_tb.sv =====
// self-checking testbench for the ray/triangle intersect block
`timescale 1ns / 100ps

module ray_triangle_intersect_top_tb;
    import rti_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [2:0]  slot;
        logic [95:0] xyz;
    } t_vec_beat;

    typedef struct packed {
        logic        hit;
        logic [31:0] hdist;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } t_isect;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [95:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;

    t_vec_beat pending_vecs[$];
    t_isect    isect_q[$];
    int        err_cnt = 0;
    int        vecs_in = 0;
    bit        quiet = 1'b0;
    bit        held = 1'b0;

    // predictor copy of the stored vectors
    logic signed [31:0] org[3], dir[3], va[3], vb[3];

    ray_triangle_intersect_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_wide det3(t_wide u0, t_wide u1, t_wide u2, t_wide v0, t_wide v1,
                                   t_wide v2, t_wide w0, t_wide w1, t_wide w2);
        return u0 * (v1 * w2 - v2 * w1) - u1 * (v0 * w2 - v2 * w0)
             + u2 * (v0 * w1 - v1 * w0);
    endfunction

    // nearest code, halves away from zero, clamped to 32-bit signed; den > 0
    function automatic logic [31:0] round_clamp(t_wide num, t_wide den);
        bit    neg;
        t_wide mag, q, lim;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (2 * mag + den) / (2 * den);
        lim = neg ? (t_wide'(1) <<< 31) : (t_wide'(1) <<< 31) - 1;
        if (q > lim) q = lim;
        if (neg) q = -q;
        return q[31:0];
    endfunction

    task automatic predict_isect(input logic [2:0] slot, input logic [95:0] xyz);
        logic signed [31:0] v[3];
        t_wide  a[3], b[3], r[3], nd[3];
        t_wide  det, n0, n1, n2, num;
        t_isect res;
        for (int i = 0; i < 3; i++) v[i] = xyz[32*i +: 32];
        case (slot)
            SLOT_ORIGIN: org = v;
            SLOT_DIR:    dir = v;
            SLOT_VA:     va = v;
            SLOT_VB:     vb = v;
            SLOT_VC: begin
                for (int i = 0; i < 3; i++) begin
                    a[i] = t_wide'(vb[i]) - t_wide'(va[i]);
                    b[i] = t_wide'(v[i]) - t_wide'(va[i]);
                    r[i] = t_wide'(org[i]) - t_wide'(va[i]);
                    nd[i] = -t_wide'(dir[i]);
                end
                det = det3(a[0], a[1], a[2], b[0], b[1], b[2], nd[0], nd[1], nd[2]);
                n0 = det3(r[0], r[1], r[2], b[0], b[1], b[2], nd[0], nd[1], nd[2]);
                n1 = det3(a[0], a[1], a[2], r[0], r[1], r[2], nd[0], nd[1], nd[2]);
                n2 = det3(a[0], a[1], a[2], b[0], b[1], b[2], r[0], r[1], r[2]);
                res = '0;
                if (det < 0) begin
                    det = -det; n0 = -n0; n1 = -n1; n2 = -n2;
                end
                if (det != 0 && n0 >= 0 && n1 >= 0 && n0 + n1 <= det) begin
                    res.hit = 1'b1;
                    res.hdist = round_clamp(n2 * (t_wide'(1) <<< 16), det);
                    num = t_wide'(va[0]) * det + n0 * a[0] + n1 * b[0];
                    res.px = round_clamp(num, det);
                    num = t_wide'(va[1]) * det + n0 * a[1] + n1 * b[1];
                    res.py = round_clamp(num, det);
                    num = t_wide'(va[2]) * det + n0 * a[2] + n1 * b[2];
                    res.pz = round_clamp(num, det);
                end
                isect_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic add_vec(input logic [2:0] slot, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
        pending_vecs.push_back({slot, z, y, x});
    endtask

    function automatic int rnd_span(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // a triangle whose plane the ray line crosses at a chosen barycentric point
    task automatic add_hit_case();
        int  av[3], bv[3], cv[3], dv[3], w0, w1, k;
        longint p;
        for (int i = 0; i < 3; i++) begin
            av[i] = rnd_span(1 << 19);
            bv[i] = rnd_span(1 << 19);
            cv[i] = rnd_span(1 << 19);
            dv[i] = rnd_span(1 << 14);
        end
        w0 = $urandom_range(0, 256);
        w1 = $urandom_range(0, 256 - w0);
        k = rnd_span(20);
        add_vec(SLOT_DIR, dv[0], dv[1], dv[2]);
        add_vec(SLOT_VA, av[0], av[1], av[2]);
        add_vec(SLOT_VB, bv[0], bv[1], bv[2]);
        for (int i = 0; i < 3; i++) begin
            p = av[i] + ((longint'(bv[i] - av[i]) * w0 + longint'(cv[i] - av[i]) * w1) >>> 8);
            dv[i] = int'(p + longint'(k) * dv[i]);
        end
        add_vec(SLOT_ORIGIN, dv[0], dv[1], dv[2]);
        add_vec(SLOT_VC, cv[0], cv[1], cv[2]);
    endtask

    // input side: beats come from the pending queue, prediction at acceptance
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                predict_isect(s_tuser, s_tdata);
                vecs_in++;
            end
            quiet = pending_vecs.size() < 100;
            if (!s_tvalid || o_s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_vecs.size() > 0) begin
                    t_vec_beat bt;
                    bt = pending_vecs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= bt.slot;
                    s_tdata <= bt.xyz;
                    if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output ready: random bursts plus one long hold-off
    int rx_gap = 0;
    int rx_hold = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!held && vecs_in >= 200) begin
                held = 1'b1;
                rx_hold = 6000;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 6);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && m_tready) begin
            t_isect got, want;
            got = {o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                   o_m_axis_tdata[95:64], o_m_axis_tdata[127:96]};
            if (isect_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = isect_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    $display("%0t: mismatch hit %b/%b dist %h/%h x %h/%h y %h/%h z %h/%h",
                             $time, want.hit, got.hit, want.hdist, got.hdist, want.px, got.px,
                             want.py, got.py, want.pz, got.pz);
                end
            end
        end
    end

    // stall watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 40000) begin
            $display("ray_triangle_intersect_top regression: fail");
            $finish;
        end
    end

    initial begin
        int pick;
        // zero determinant straight after reset
        add_vec(SLOT_VC, 32'h0001_0000, 32'h0, 32'h0);
        add_vec(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_vec(6, 32'h0, 32'h0, 32'h0);
        add_vec(7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        // unit triangle in z = 0, ray along z: far origins saturate the distance
        add_vec(SLOT_VA, 32'h0, 32'h0, 32'h0);
        add_vec(SLOT_VB, 32'h0001_0000, 32'h0, 32'h0);
        add_vec(SLOT_DIR, 32'h0, 32'h0, 32'h1);
        add_vec(SLOT_ORIGIN, 32'h4000, 32'h4000, 32'h7FFF_FFFF);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        add_vec(SLOT_ORIGIN, 32'h4000, 32'h4000, 32'h8000_0000);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        // exact corner, exact edge at a negative distance, just outside
        add_vec(SLOT_DIR, 32'h0, 32'h0, 32'h0001_0000);
        add_vec(SLOT_ORIGIN, 32'h0001_0000, 32'h0, 32'hFFFE_0000);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        add_vec(SLOT_ORIGIN, 32'h8000, 32'h8000, 32'h0003_0000);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        add_vec(SLOT_ORIGIN, 32'h8001, 32'h8000, 32'h0003_0000);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        // direction in the plane: zero determinant
        add_vec(SLOT_DIR, 32'h0001_0000, 32'h0, 32'h0);
        add_vec(SLOT_VC, 32'h0, 32'h0001_0000, 32'h0);
        // extreme coordinates everywhere
        add_vec(SLOT_ORIGIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_vec(SLOT_DIR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_vec(SLOT_VA, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_vec(SLOT_VB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_vec(SLOT_VC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

        while (pending_vecs.size() < 800) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                add_hit_case();
            end else if (pick < 75) begin
                for (int s = 0; s < 5; s++) add_vec(s, $urandom, $urandom, $urandom);
            end else if (pick < 85) begin
                add_vec($urandom_range(0, 3), $urandom, $urandom, $urandom);
                add_vec(SLOT_VC, rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20));
            end else if (pick < 95) begin
                add_vec($urandom_range(5, 7), $urandom, $urandom, $urandom);
            end else begin
                for (int s = 0; s < 5; s++)
                    add_vec(s, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                            $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                            $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_vecs.size() > 0 || s_tvalid || isect_q.size() > 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
        if (err_cnt == 0 && isect_q.size() == 0)
            $display("ray_triangle_intersect_top regression: pass");
        else
            $display("ray_triangle_intersect_top regression: fail");
        $finish;
    end

endmodule
